@@ rtl/sha256_stream_hasher_defines.svh @@
// Assertion macros shared by the SHA-256 stream hasher RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sha_pkg.sv @@
// Package for the SHA-256 stream hasher: round constants, initial hash and types.
// Depends on nothing.
`default_nettype none
package sha_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;

  typedef enum logic [2:0] {
    StIdle,
    StPad,
    StLoad,
    StRound,
    StAdd,
    StOut
  } state_e;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

endpackage
`default_nettype wire

@@ rtl/sha256_stream_hasher.sv @@
// SHA-256 stream hasher: block buffer memory, 16-word schedule and one-round compressor.
// Depends on sha_pkg and sha256_stream_hasher_defines.svh.
//
// Use: the slave channel carries one word per transfer: s_axis_tdata is the
// message byte and s_axis_tuser is the command (0 absorb, 1 finish).
// Absorbed bytes are written into a 64-entry block memory, one per cycle
// while the hasher is idle. The 64th byte of a block starts the compression:
// the load state reads the block memory byte by byte into the schedule, the
// round state runs the 64 rounds and the add state adds into the chaining
// state, with the input held off throughout. A finish pads the block in
// memory byte by byte, compresses one or two blocks, then presents the
// eight digest words on the master channel, word 0 first, m_axis_tlast on
// word 7. While the receiver holds m_axis_tready low the current digest
// word stays put and no new word is accepted. After the last digest word
// is taken the block returns to the initial hash and a zero length. Reset
// does the same at once; the block memory itself needs no clearing.
`default_nettype none
`include "sha256_stream_hasher_defines.svh"
module sha256_stream_hasher
  import sha_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  wire logic        s_axis_tuser,   // cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,        // digest_word[31:0], word_index[34:32], zeros
  output logic             m_axis_tlast    // last_word
);

  state_e state_q, state_d;

  logic [7:0]  mem_q [BlockBytes];
  logic [7:0]  rd_q;
  logic [6:0]  fill_q, fill_d;
  logic [63:0] bits_q, bits_d;
  logic [63:0] total_q, total_d;
  logic        final_q, final_d;
  logic        extra_q, extra_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [2:0]  oidx_q, oidx_d;

  logic        mem_we;
  logic [5:0]  mem_wa, mem_ra;
  logic [7:0]  mem_wd;
  logic        s_acc;
  logic [5:0]  pos;

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == StIdle);
  assign pos = fill_q[5:0];

  // Block memory write data: the input byte while idle, else the padding byte for position fill_q.
  always_comb begin
    mem_wd = 8'h00;
    if (state_q == StIdle) begin
      mem_wd = s_axis_tdata;
    end else if (cnt_q == 7'd0) begin
      mem_wd = 8'h80;
    end else if (final_q && pos >= 6'd56) begin
      mem_wd = total_q[8'(63 - 8 * (32'(pos) - 56)) -: 8];
    end
  end

  always_comb begin
    mem_we = (s_acc && !s_axis_tuser) || (state_q == StPad);
    mem_wa = pos;
    mem_ra = {cnt_q[3:0], 2'b00} + 6'(cnt_q[5:4]);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rd_q <= mem_q[mem_ra];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    bits_d  = bits_q;
    total_d = total_q;
    final_d = final_q;
    extra_d = extra_q;
    cnt_d   = cnt_q;
    oidx_d  = oidx_q;
    case (state_q)
      StIdle: begin
        if (s_acc) begin
          cnt_d = 7'd0;
          if (s_axis_tuser) begin
            total_d = bits_q + {55'd0, pos, 3'b000};
            final_d = (pos < 6'd56);
            extra_d = 1'b0;
            state_d = StPad;
          end else if (pos == 6'd63) begin
            fill_d  = 7'd0;
            final_d = 1'b0;
            extra_d = 1'b0;
            cnt_d   = 7'd0;
            state_d = StLoad;
          end else begin
            fill_d = fill_q + 7'd1;
          end
        end
      end
      StPad: begin
        cnt_d = 7'd1;
        if (pos == 6'd63) begin
          fill_d  = 7'd0;
          cnt_d   = 7'd0;
          state_d = StLoad;
        end else begin
          fill_d = fill_q + 7'd1;
        end
      end
      StLoad: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd64) begin
          cnt_d   = 7'd0;
          state_d = StRound;
        end
      end
      StRound: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd63) state_d = StAdd;
      end
      StAdd: begin
        if (final_q) begin
          oidx_d  = 3'd0;
          state_d = StOut;
        end else if (extra_q) begin
          final_d = 1'b1;
          extra_d = 1'b1;
          cnt_d   = 7'd1;
          state_d = StPad;
        end else begin
          bits_d  = bits_q + 64'd512;
          state_d = StIdle;
        end
      end
      StOut: begin
        if (m_axis_tready) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            bits_d  = 64'd0;
            final_d = 1'b0;
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
    // An overflow pad block leads into a length-only block.
    if (state_q == StIdle && s_acc && s_axis_tuser && pos >= 6'd56) extra_d = 1'b1;
  end

  // Outputs.
  always_comb begin
    m_axis_tvalid = (state_q == StOut);
    m_axis_tlast  = (oidx_q == 3'd7);
    m_axis_tdata  = {5'd0, oidx_q, h_q[oidx_q]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fill_q  <= 7'd0;
      bits_q  <= 64'd0;
      final_q <= 1'b0;
      extra_q <= 1'b0;
      cnt_q   <= 7'd0;
      oidx_q  <= 3'd0;
      total_q <= 64'd0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      bits_q  <= bits_d;
      final_q <= final_d;
      extra_q <= extra_d;
      cnt_q   <= cnt_d;
      oidx_q  <= oidx_d;
      total_q <= total_d;
    end
  end

  // Datapath: schedule window, working variables and chaining state.
  logic [31:0] s0, s1, wnew, big1, ch, t1, big0, maj, t2;
  always_comb begin
    s0   = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^ (w_q[1] >> 3);
    s1   = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
         ^ (w_q[14] >> 10);
    wnew = s1 + w_q[9] + s0 + w_q[0];
    big1 = {v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
         ^ {v_q[4][24:0], v_q[4][31:25]};
    ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1   = v_q[7] + big1 + ch + round_k(cnt_q[5:0]) + w_q[0];
    big0 = {v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
         ^ {v_q[0][21:0], v_q[0][31:22]};
    maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2   = big0 + maj;
  end

  // Load: memory address cnt reads byte (cnt[3:0]*4 + cnt[5:4]); the read data is registered in rd_q.
  logic [6:0] lc;
  assign lc = cnt_q - 7'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
    end else if (state_q == StAdd) begin
      for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
    end else if (state_q == StOut && m_axis_tready && oidx_q == 3'd7) begin
      for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StLoad && cnt_q != 7'd0) begin
      w_q[lc[3:0]][8'(31 - 8 * 32'(lc[5:4])) -: 8] <= rd_q;
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (state_q == StRound) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
      w_q[15] <= wnew;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  `SHA_ASSERT_IMP(a_no_in_busy, clk_i, rst_ni, state_q != StIdle, !s_axis_tready,
                  "input taken while busy")
  `SHA_ASSERT_NEXT(a_round_to_add, clk_i, rst_ni, state_q == StRound && cnt_q == 7'd63,
                   state_q == StAdd, "round count overran")
  `SHA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(oidx_q), "digest word not held on stall")
  `SHA_ASSERT_NEXT(a_last_done, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && m_axis_tlast,
                   state_q == StIdle && bits_q == 64'd0, "no reinit after digest")

endmodule
`default_nettype wire

@@ verif/tb_sha256_stream_hasher.sv @@
// Testbench for the SHA-256 stream hasher: drives message bytes and finish
// commands, predicts every digest word and checks each one in order.
// Depends on sha_pkg and the sha256_stream_hasher RTL.
`timescale 1ns / 1ps

class digest_scoreboard;
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_t;

  logic [31:0] chain[8];
  logic [7:0]  block[64];
  int unsigned fill;
  logic [63:0] length_bits;
  digest_t     pending[$];
  int unsigned errors;

  function new();
    errors = 0;
    restart();
  endfunction

  function void restart();
    chain[0] = 32'h6a09e667; chain[1] = 32'hbb67ae85;
    chain[2] = 32'h3c6ef372; chain[3] = 32'ha54ff53a;
    chain[4] = 32'h510e527f; chain[5] = 32'h9b05688c;
    chain[6] = 32'h1f83d9ab; chain[7] = 32'h5be0cd19;
    fill = 0;
    length_bits = '0;
  endfunction

  function logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function void compress();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {block[4*i], block[4*i+1], block[4*i+2], block[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::round_k(i[5:0]) + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int j = 7; j > 0; j--) v[j] = v[j-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endfunction

  function void note_input(logic finish, logic [7:0] data);
    logic [63:0] total;
    digest_t d;
    if (!finish) begin
      block[fill] = data;
      fill++;
      if (fill == 64) begin
        compress();
        length_bits += 64'd512;
        fill = 0;
      end
      return;
    end
    total = length_bits + 64'(fill) * 8;
    block[fill] = 8'h80;
    for (int i = fill + 1; i < 64; i++) block[i] = '0;
    if (fill >= 56) begin
      compress();
      for (int i = 0; i < 56; i++) block[i] = '0;
    end
    for (int i = 0; i < 8; i++) block[56+i] = total[63-8*i -: 8];
    compress();
    for (int i = 0; i < 8; i++) begin
      d.word = chain[i];
      d.index = i[2:0];
      d.last = (i == 7);
      pending.push_back(d);
    end
    restart();
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch: %s got %h expected %h", what, got, want);
    errors++;
  endtask

  task check_result(logic [39:0] tdata, logic tlast);
    digest_t d;
    if (pending.size() == 0) begin
      report("unexpected word", tdata[31:0], '0);
      return;
    end
    d = pending.pop_front();
    if (tdata[31:0] !== d.word) report("digest word", tdata[31:0], d.word);
    if (tdata[34:32] !== d.index) report("word index", tdata[34:32], d.index);
    if (tdata[39:35] !== '0) report("padding bits", tdata[39:35], '0);
    if (tlast !== d.last) report("last flag", tlast, d.last);
  endtask
endclass

module tb_sha256_stream_hasher;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  digest_scoreboard hash_board = new();
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_off = 0;
  bit          hold_req = 1'b0;
  bit          hold_started = 1'b0;
  int unsigned cycles = 0;
  bit          stim_done = 1'b0;

  localparam int unsigned CycleLimit = 2_000_000;

  sha256_stream_hasher dut (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      hash_board.check_result(m_axis_tdata, m_axis_tlast);
    if (hold_req && !hold_started) begin
      hold_started <= 1'b1;
      hold_off <= 3000;
      m_axis_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_word(logic finish, logic [7:0] data);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= finish;
    s_axis_tdata <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    hash_board.note_input(finish, data);
  endtask

  task automatic send_message(int unsigned len, int unsigned fill_kind);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (fill_kind)
        0: b = 8'h00;
        1: b = 8'hff;
        default: b = 8'($urandom_range(255));
      endcase
      send_word(1'b0, b);
    end
    send_word(1'b1, 8'($urandom_range(255)));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (hash_board.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned pick;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty, 1-byte and 3-byte messages, padding boundaries at 55 and 56 bytes, full block, empty message.
    send_message(0, 2);
    send_message(1, 1);
    send_message(3, 2);
    send_message(55, 0);
    send_message(56, 1);
    send_message(64, 2);
    send_word(1'b1, 8'hff);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 87; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 87; end
        3: begin send_idle_pct = 7;  stall_pct = 7;  end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      if (ph == 4) begin
        hold_req = 1'b1;
        for (int m = 0; m < 2; m++) send_message($urandom_range(10), 2);
      end else begin
        for (int m = 0; m < 2; m++) begin
          pick = $urandom_range(9);
          send_message(pick < 9 ? $urandom_range(10) : $urandom_range(50, 70), 2);
        end
      end
      drain();
    end

    stall_pct = 0;
    send_idle_pct = 0;
    drain();
    repeat (200) @(posedge clk_i);
    if (hash_board.errors == 0 && hash_board.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/sha_pkg.sv
rtl/sha256_stream_hasher.sv
verif/tb_sha256_stream_hasher.sv
